// ----- hdl/bisec_pkg.sv -----
// ----------------------------------------------------------------------------
// bisec_pkg
// Shared types and constants for the bisection root finder: payload structs,
// register indexes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package bisec_pkg;

    // fixed field widths
    localparam int WORD_BITS          = 32;
    localparam int HALF_BITS          = WORD_BITS / 2;
    localparam int CFG_BITS           = 31;
    localparam int CFG_IDX_BITS       = 2;
    localparam int FRACTION_BITS_DEF  = 20;

    // register reset values
    localparam logic [CFG_BITS-1:0] SQUARE_OFFSET_RST = CFG_BITS'(3145728);
    localparam logic [CFG_BITS-1:0] TOLERANCE_RST     = CFG_BITS'(1);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SQUARE_OFFSET = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE     = CFG_IDX_BITS'(1);

    // input item
    typedef struct packed {
        logic signed [WORD_BITS-1:0] interval_low;
        logic signed [WORD_BITS-1:0] interval_high;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [WORD_BITS-1:0] root_value;
        logic                        no_sign_change;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_CMP_A,
        S_MUL_B,
        S_CMP_B,
        S_ITER,
        S_CMP_C
    } t_state;

    // operand of the squaring unit
    typedef enum logic [1:0] {
        SQ_A,
        SQ_B,
        SQ_C
    } t_sq_sel;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    sq_en;
        t_sq_sel sq_sel;
        logic    save_sa;
        logic    upd_a;
        logic    upd_b;
        logic    load_res;
        logic    res_err;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic f_pos;
        logic f_zero;
        logic sa_pos;
        logic sa_zero;
        logic go_on;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/bisection_root_finder_top.sv -----
// ----------------------------------------------------------------------------
// bisection_root_finder_top
// Bisection search for a root of x*x - k over a signed fixed-point interval.
// ----------------------------------------------------------------------------
// result: strobed after the end-point checks if the ends show no sign change,
//   else when the halving steps end or a midpoint is an exact root
// throughput: one item at a time; each halving step uses the split squaring
//   unit and then the wide sum and compare
// reset: synchronous, active low; clears the controller and loads
//   k = 3.0 and tolerance = 1; results cannot be stalled by the receiver
`default_nettype none

module bisection_root_finder_top #(
    parameter int FRACTION_BITS = bisec_pkg::FRACTION_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  bisec_pkg::t_in_item                i_item,
    output logic                               o_done,
    output bisec_pkg::t_out_item               o_out,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [bisec_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire  [bisec_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import bisec_pkg::*;

    logic [CFG_BITS-1:0] r_square_offset;
    logic [CFG_BITS-1:0] r_tolerance;
    t_dp_cmd             cmd;
    t_dp_stat            stat;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square_offset <= SQUARE_OFFSET_RST;
            r_tolerance     <= TOLERANCE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SQUARE_OFFSET: r_square_offset <= i_cfg_data;
                CFG_TOLERANCE:     r_tolerance     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // controller
    bisec_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath
    bisec_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_item          (i_item),
        .i_square_offset (r_square_offset),
        .i_tolerance     (r_tolerance),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out           (o_out)
    );

    // checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.no_sign_change) |-> (o_out.root_value == '0))
        else $error("error item carries a nonzero root");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the search");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

// ----- hdl/bisec_dp.sv -----
// ----------------------------------------------------------------------------
// bisec_dp
// Datapath: interval registers, midpoint and width test, split squaring unit,
// exact compare of x*x against k scaled to the fixed-point format.
// ----------------------------------------------------------------------------
`default_nettype none

module bisec_dp #(
    parameter int FRACTION_BITS = bisec_pkg::FRACTION_BITS_DEF
) (
    input  wire                               i_clk,
    input  bisec_pkg::t_in_item               i_item,
    input  wire  [bisec_pkg::CFG_BITS-1:0]    i_square_offset,
    input  wire  [bisec_pkg::CFG_BITS-1:0]    i_tolerance,
    input  bisec_pkg::t_dp_cmd                i_cmd,
    output bisec_pkg::t_dp_stat               o_stat,
    output bisec_pkg::t_out_item              o_out
);
    import bisec_pkg::*;

    localparam int CW = (2 * WORD_BITS > CFG_BITS + FRACTION_BITS) ?
                        2 * WORD_BITS : CFG_BITS + FRACTION_BITS;
    localparam int DW = (WORD_BITS + 2 > CFG_BITS + 2) ? WORD_BITS + 2 : CFG_BITS + 2;

    logic signed [WORD_BITS-1:0]   r_a;
    logic signed [WORD_BITS-1:0]   r_b;
    logic                          r_sa_pos;
    logic                          r_sa_zero;
    logic        [2*HALF_BITS-1:0] r_p_ll;
    logic        [2*HALF_BITS-1:0] r_p_lh;
    logic        [2*HALF_BITS-1:0] r_p_hh;
    t_out_item                     r_out;

    logic signed [WORD_BITS:0]     sum_ab;
    logic signed [WORD_BITS-1:0]   mid;
    logic signed [DW-1:0]          width;
    logic signed [DW-1:0]          twice_tol;
    logic signed [WORD_BITS-1:0]   sq_op;
    logic        [WORD_BITS-1:0]   mag;
    logic        [HALF_BITS-1:0]   mag_lo;
    logic        [HALF_BITS-1:0]   mag_hi;
    logic        [CW-1:0]          square;
    logic        [CW-1:0]          k_scaled;

    // midpoint, floor of the exact sum over two
    assign sum_ab = (WORD_BITS+1)'(r_a) + (WORD_BITS+1)'(r_b);
    assign mid    = sum_ab[WORD_BITS:1];

    // keep going while width exceeds twice the tolerance and one unit
    assign width     = DW'(r_b) - DW'(r_a);
    assign twice_tol = signed'(DW'({i_tolerance, 1'b0}));

    // operand select and magnitude
    always_comb begin
        case (i_cmd.sq_sel)
            SQ_A:    sq_op = r_a;
            SQ_B:    sq_op = r_b;
            default: sq_op = mid;
        endcase
    end

    assign mag    = sq_op[WORD_BITS-1] ? WORD_BITS'(-sq_op) : WORD_BITS'(sq_op);
    assign mag_lo = mag[HALF_BITS-1:0];
    assign mag_hi = mag[2*HALF_BITS-1:HALF_BITS];

    // partial products of the square
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_en) begin
            r_p_ll <= mag_lo * mag_lo;
            r_p_lh <= mag_lo * mag_hi;
            r_p_hh <= mag_hi * mag_hi;
        end
    end

    // sum of partial products against k in the same format
    assign square   = (CW'(r_p_hh) << (2 * HALF_BITS)) + (CW'(r_p_lh) << (HALF_BITS + 1))
                    + CW'(r_p_ll);
    assign k_scaled = CW'(i_square_offset) << FRACTION_BITS;

    assign o_stat.f_pos   = square > k_scaled;
    assign o_stat.f_zero  = square == k_scaled;
    assign o_stat.sa_pos  = r_sa_pos;
    assign o_stat.sa_zero = r_sa_zero;
    assign o_stat.go_on   = (width > twice_tol) && (width > signed'(DW'(1)));

    // interval ends
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_item.interval_low;
            r_b <= i_item.interval_high;
        end else if (i_cmd.upd_a) begin
            r_a <= mid;
        end else if (i_cmd.upd_b) begin
            r_b <= mid;
        end
    end

    // sign of f at the left end
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_sa) begin
            r_sa_pos  <= o_stat.f_pos;
            r_sa_zero <= o_stat.f_zero;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_out.root_value     <= i_cmd.res_err ? '0 : mid;
            r_out.no_sign_change <= i_cmd.res_err;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ----- hdl/bisec_ctrl.sv -----
// ----------------------------------------------------------------------------
// bisec_ctrl
// Controller: sequences the end-point sign checks and the bisection loop,
// running S_ITER then S_CMP_C for each halving step, and strobes the finished item.
// ----------------------------------------------------------------------------
`default_nettype none

module bisec_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    output logic                 o_busy,
    output logic                 o_done,
    input  bisec_pkg::t_dp_stat  i_stat,
    output bisec_pkg::t_dp_cmd   o_cmd
);
    import bisec_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    // state register and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.load_res;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sq_sel = SQ_A;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = SQ_A;
                n_state      = S_CMP_A;
            end
            S_CMP_A: begin
                o_cmd.save_sa = 1'b1;
                n_state       = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = SQ_B;
                n_state      = S_CMP_B;
            end
            S_CMP_B: begin
                // zero at either end or equal signs: no search
                if (i_stat.sa_zero || i_stat.f_zero || (i_stat.sa_pos == i_stat.f_pos)) begin
                    o_cmd.load_res = 1'b1;
                    o_cmd.res_err  = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_ITER;
                end
            end
            S_ITER: begin
                if (i_stat.go_on) begin
                    o_cmd.sq_en  = 1'b1;
                    o_cmd.sq_sel = SQ_C;
                    n_state      = S_CMP_C;
                end else begin
                    o_cmd.load_res = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CMP_C: begin
                // exact root at the midpoint ends the search
                if (i_stat.f_zero) begin
                    o_cmd.load_res = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    if (i_stat.f_pos != i_stat.sa_pos) begin
                        o_cmd.upd_b = 1'b1;
                    end else begin
                        o_cmd.upd_a = 1'b1;
                    end
                    n_state = S_ITER;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire
